// ----- hw/rtl/handle_access_policy_table_assert.svh -----
// assertion macros used by handle_access_policy_table.sv
// both expect i_clk and an active-low i_rst_n in scope
`ifndef HANDLE_ACCESS_POLICY_TABLE_ASSERT_SVH
`define HANDLE_ACCESS_POLICY_TABLE_ASSERT_SVH

// same-cycle implication
`define HAPT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define HAPT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/hapt_pkg.sv -----
`default_nettype none

package hapt_pkg;

    // authority codes
    localparam logic [1:0] AUTH_NONE  = 2'd0;
    localparam logic [1:0] AUTH_ALL   = 2'd1;
    localparam logic [1:0] AUTH_WONLY = 2'd2;
    localparam logic [1:0] AUTH_RW    = 2'd3;

    // verdict codes
    localparam logic [1:0] V_PASS = 2'd0;
    localparam logic [1:0] V_TERM = 2'd1;
    localparam logic [1:0] V_FAKE = 2'd2;

    // call classes
    localparam logic [2:0] CLS_HARMLESS = 3'd0;
    localparam logic [2:0] CLS_OPEN     = 3'd1;
    localparam logic [2:0] CLS_CLOSE    = 3'd2;
    localparam logic [2:0] CLS_READ     = 3'd3;
    localparam logic [2:0] CLS_WRITE    = 3'd4;

    // status codes
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_OOR    = 2'd1;
    localparam logic [1:0] ST_HALTED = 2'd2;

    typedef struct packed {
        logic       may_read;
        logic [1:0] auth;
    } t_entry;

    localparam t_entry ENTRY_RESET = '{may_read: 1'b1, auth: AUTH_NONE};

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] fake_return;
        logic        override_return;
        logic        cancel_call;
        logic [1:0]  verdict;
        logic        at_exit;
    } t_result;

endpackage

`default_nettype wire

// ----- hw/rtl/handle_access_policy_table.sv -----
// handle access policy table
// slave channel s_axis_*: one item per traced stop or inherited-handle mark;
// master channel m_axis_*: exactly one result item for every input item, in order.
// an item is taken when tvalid and tready are both high.
// the per-handle authority and may-read bits live in one single-port-write ram
// with a registered read; each item reads its entry on the accept edge and
// writes it back in the execute step; the block takes no new item until the
// current one has left the execute step, where its result is registered into
// the output register that drives m_axis.
// after reset the block sweeps the ram once, one entry a cycle, to authority
// none and may-read 1: s_axis_tready stays low until the sweep is done.
// the result sits in an output register; while it waits the next item is still
// taken, and that item then holds in the execute step until the output frees up.
// a terminate verdict or an out-of-range handle halts the block: every later
// item returns status already-halted until the next reset.
`default_nettype none

`include "handle_access_policy_table_assert.svh"

module handle_access_policy_table #(
    parameter int HANDLE_SLOTS = 1024
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // handle_number[15:0], call_return[47:16], create_flag[48], own_log[49],
    // regdir_flag[50], byte_count[81:51], zero pad[87:82]
    input  wire logic [87:0] s_axis_tdata,
    // mode[0], call_class[3:1]
    input  wire logic [3:0]  s_axis_tuser,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // verdict[1:0], cancel_call[2], override_return[3], fake_return[35:4],
    // status[37:36], zero pad[39:38]
    output logic [39:0]      m_axis_tdata,
    // at_exit[0]
    output logic [0:0]       m_axis_tuser
);

    localparam int AW = $clog2(HANDLE_SLOTS);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC
    } t_state;

    t_state r_state, n_state;
    logic [AW-1:0] r_clr, n_clr;
    logic r_in_call, n_in_call;
    logic [1:0] r_pend, n_pend;
    logic [1:0] r_lastv, n_lastv;
    logic [31:0] r_fake, n_fake;
    logic r_halted, n_halted;
    logic r_out_valid, n_out_valid;
    hapt_pkg::t_result r_out, n_out;

    // captured item
    logic r_mode;
    logic [2:0] r_cls;
    logic signed [15:0] r_h;
    logic signed [31:0] r_ret;
    logic r_create, r_logf, r_regdir;
    logic [30:0] r_cnt;
    logic [AW-1:0] r_addr;

    logic w_accept;
    logic w_exec_go;
    logic [AW-1:0] w_in_addr;
    logic w_slot_h, w_slot_ret;
    logic [1:0] w_verdict;

    logic w_ram_we;
    logic [AW-1:0] w_ram_waddr, w_ram_raddr;
    hapt_pkg::t_entry w_ram_wdata, w_rd;

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_accept = s_axis_tvalid && s_axis_tready;
    assign w_exec_go = (r_state == S_EXEC) && (!r_out_valid || m_axis_tready);

    // open exit binds to the returned handle, everything else uses the handle argument
    assign w_in_addr = (r_in_call && s_axis_tuser[0] && s_axis_tuser[3:1] == hapt_pkg::CLS_OPEN)
                       ? s_axis_tdata[16 +: AW] : s_axis_tdata[AW-1:0];

    assign w_slot_h = !r_h[15] && ({1'b0, r_h} < 17'(HANDLE_SLOTS));
    assign w_slot_ret = !r_ret[31] && ({1'b0, r_ret} < 33'(HANDLE_SLOTS));

    hapt_ram #(
        .WIDTH ($bits(hapt_pkg::t_entry)),
        .DEPTH (HANDLE_SLOTS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_raddr (w_ram_raddr),
        .o_rdata (w_rd)
    );

    always_comb begin
        n_state = r_state;
        n_clr = r_clr;
        n_in_call = r_in_call;
        n_pend = r_pend;
        n_lastv = r_lastv;
        n_fake = r_fake;
        n_halted = r_halted;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_out = r_out;
        w_verdict = hapt_pkg::V_PASS;
        w_ram_we = 1'b0;
        w_ram_waddr = r_addr;
        w_ram_wdata = w_rd;
        w_ram_raddr = r_addr;

        unique case (r_state)
            S_CLEAR: begin
                w_ram_we = 1'b1;
                w_ram_waddr = r_clr;
                w_ram_wdata = hapt_pkg::ENTRY_RESET;
                if (r_clr == AW'(HANDLE_SLOTS - 1)) begin
                    n_state = S_IDLE;
                end else begin
                    n_clr = r_clr + 1'b1;
                end
            end
            S_IDLE: begin
                w_ram_raddr = w_in_addr;
                if (w_accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (w_exec_go) begin
                    n_out = '0;
                    n_out_valid = 1'b1;
                    n_state = S_IDLE;
                    if (r_halted) begin
                        n_out.status = hapt_pkg::ST_HALTED;
                    end else if (!r_mode) begin
                        if (w_slot_h) begin
                            w_ram_we = 1'b1;
                            w_ram_wdata = '{may_read: w_rd.may_read, auth: hapt_pkg::AUTH_WONLY};
                        end else begin
                            n_out.status = hapt_pkg::ST_OOR;
                            n_halted = 1'b1;
                        end
                    end else if (!r_in_call) begin
                        n_in_call = 1'b1;
                        case (r_cls) inside
                            hapt_pkg::CLS_HARMLESS, hapt_pkg::CLS_CLOSE: begin
                                w_verdict = hapt_pkg::V_PASS;
                            end
                            hapt_pkg::CLS_OPEN: begin
                                if (r_logf) begin
                                    n_pend = hapt_pkg::AUTH_ALL;
                                end else if (r_create) begin
                                    n_pend = hapt_pkg::AUTH_NONE;
                                    w_verdict = hapt_pkg::V_TERM;
                                end else begin
                                    n_pend = r_regdir ? hapt_pkg::AUTH_RW : hapt_pkg::AUTH_WONLY;
                                end
                            end
                            hapt_pkg::CLS_READ: begin
                                if (!w_slot_h) begin
                                    n_out.status = hapt_pkg::ST_OOR;
                                    n_halted = 1'b1;
                                end else if (w_rd.auth == hapt_pkg::AUTH_ALL ||
                                             (w_rd.auth == hapt_pkg::AUTH_RW && w_rd.may_read)) begin
                                    w_verdict = hapt_pkg::V_PASS;
                                end else begin
                                    w_verdict = hapt_pkg::V_TERM;
                                end
                            end
                            hapt_pkg::CLS_WRITE: begin
                                if (!w_slot_h) begin
                                    n_out.status = hapt_pkg::ST_OOR;
                                    n_halted = 1'b1;
                                end else begin
                                    case (w_rd.auth)
                                        hapt_pkg::AUTH_ALL:   w_verdict = hapt_pkg::V_PASS;
                                        hapt_pkg::AUTH_WONLY: w_verdict = hapt_pkg::V_FAKE;
                                        hapt_pkg::AUTH_RW: begin
                                            w_verdict = hapt_pkg::V_FAKE;
                                            w_ram_we = 1'b1;
                                            w_ram_wdata = '{may_read: 1'b0, auth: w_rd.auth};
                                        end
                                        default: w_verdict = hapt_pkg::V_TERM;
                                    endcase
                                    if (w_verdict == hapt_pkg::V_FAKE) begin
                                        n_fake = {1'b0, r_cnt};
                                    end
                                end
                            end
                            default: begin
                                w_verdict = hapt_pkg::V_TERM;
                            end
                        endcase
                        if (n_out.status == hapt_pkg::ST_OK) begin
                            n_out.verdict = w_verdict;
                            n_lastv = w_verdict;
                            n_halted = (w_verdict == hapt_pkg::V_TERM);
                            n_out.cancel_call = (w_verdict == hapt_pkg::V_FAKE);
                        end
                    end else begin
                        n_in_call = 1'b0;
                        n_out.at_exit = 1'b1;
                        if (r_lastv == hapt_pkg::V_FAKE) begin
                            // faked call never ran: only substitute the return value
                            n_out.override_return = 1'b1;
                            n_out.fake_return = r_fake;
                        end else if (r_cls == hapt_pkg::CLS_OPEN && !r_ret[31]) begin
                            if (w_slot_ret) begin
                                w_ram_we = 1'b1;
                                w_ram_wdata = '{may_read: w_rd.may_read, auth: r_pend};
                            end else begin
                                n_out.status = hapt_pkg::ST_OOR;
                                n_halted = 1'b1;
                            end
                        end else if (r_cls == hapt_pkg::CLS_CLOSE && !r_ret[31]) begin
                            if (w_slot_h) begin
                                w_ram_we = 1'b1;
                                w_ram_wdata = hapt_pkg::ENTRY_RESET;
                            end else begin
                                n_out.status = hapt_pkg::ST_OOR;
                                n_halted = 1'b1;
                            end
                        end
                        n_lastv = hapt_pkg::V_PASS;
                    end
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr <= '0;
            r_in_call <= 1'b0;
            r_pend <= hapt_pkg::AUTH_NONE;
            r_lastv <= hapt_pkg::V_PASS;
            r_fake <= '0;
            r_halted <= 1'b0;
            r_out_valid <= 1'b0;
            r_out <= '0;
        end else begin
            r_state <= n_state;
            r_clr <= n_clr;
            r_in_call <= n_in_call;
            r_pend <= n_pend;
            r_lastv <= n_lastv;
            r_fake <= n_fake;
            r_halted <= n_halted;
            r_out_valid <= n_out_valid;
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_mode <= s_axis_tuser[0];
            r_cls <= s_axis_tuser[3:1];
            r_h <= s_axis_tdata[15:0];
            r_ret <= s_axis_tdata[47:16];
            r_create <= s_axis_tdata[48];
            r_logf <= s_axis_tdata[49];
            r_regdir <= s_axis_tdata[50];
            r_cnt <= s_axis_tdata[81:51];
            r_addr <= w_in_addr;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata = {2'b00, r_out.status, r_out.fake_return, r_out.override_return,
                           r_out.cancel_call, r_out.verdict};
    assign m_axis_tuser = r_out.at_exit;

    `HAPT_ASSERT_NEXT(a_halt_sticky, r_halted, r_halted, "halt flag dropped without reset")
    `HAPT_ASSERT_NOW(a_ram_we_src, w_ram_we, (r_state == S_CLEAR) || w_exec_go, "table write outside clear or execute")
    `HAPT_ASSERT_NEXT(a_halted_status, w_exec_go && r_halted, r_out.status == hapt_pkg::ST_HALTED, "halted item without halted status")
    `HAPT_ASSERT_NOW(a_ovr_at_exit, r_out_valid && r_out.override_return, r_out.at_exit && r_out.verdict == hapt_pkg::V_PASS, "return override outside a call exit")

endmodule

`default_nettype wire

// ----- hw/rtl/hapt_ram.sv -----
`default_nettype none

module hapt_ram #(
    parameter int WIDTH = 3,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire
